// ----- hdl/ipv4p_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the strict dotted-decimal IPv4 parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

	localparam int CHAR_W    = 8;
	localparam int ADDR_W    = 32;
	localparam int OCTET_W   = 8;
	localparam int VALUE_W   = 10;  // holds up to three digits (999)
	localparam int DCNT_W    = 2;
	localparam int OCNT_W    = 2;   // octets closed by a dot, 0..3

	localparam logic [CHAR_W-1:0]  CH_NUL  = 8'h00;
	localparam logic [CHAR_W-1:0]  CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0]  CH_DOT  = 8'h2E;
	localparam logic [VALUE_W-1:0] OCTET_MAX  = 10'd255;
	localparam logic [DCNT_W-1:0]  MAX_DIGITS = 2'd3;
	localparam logic [OCNT_W-1:0]  LAST_DOTS  = 2'd3;   // dots in a full address

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] addr;
	} parse_res_t;

endpackage

// ----- hdl/strict_ipv4_dotted_parser.sv -----
// ----------------------------------------------------------------------------
// strict_ipv4_dotted_parser
// Streams a NUL-terminated string and reports a strict dotted-quad IPv4 address.
// ----------------------------------------------------------------------------
// One character per request, one request per cycle while input ready is high.
// Each character is registered, then folded into the parse state as it leaves
// that register; a NUL produces one registered result request (tuser = valid
// flag, tdata = address, zero when invalid) and the state clears for the next
// string. Input ready drops only while a NUL waits behind an unread result.
module strict_ipv4_dotted_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ipv4p_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] ch
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ipv4p_pkg::ADDR_W-1:0]  m_axis_tdata,   // [31:0] address
	output logic                          m_axis_tuser    // [0] valid_res
);
	import ipv4p_pkg::*;

	logic              vld_s1;
	logic [CHAR_W-1:0] ch_s1;
	logic              is_term;
	logic              stall;
	logic              adv;
	parse_res_t        res;
	logic              res_ok_q;
	logic [ADDR_W-1:0] res_addr_q;

	assign is_term       = (ch_s1 == CH_NUL);
	assign stall         = vld_s1 && is_term && m_axis_tvalid && !m_axis_tready;
	assign adv           = vld_s1 && !stall;
	assign s_axis_tready = !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	ipv4p_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.ch     (ch_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv && is_term) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_term) begin
			res_ok_q   <= res.ok;
			res_addr_q <= res.addr;
		end
	end

	assign m_axis_tuser = res_ok_q;
	assign m_axis_tdata = res_addr_q;

	// invalid strings always report a zero address
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero address");

	// input only backs up behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a terminator that leaves stage 1 always yields a result
	a_term_res: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_term |=> m_axis_tvalid)
		else $error("terminator produced no result");

endmodule

// ----- hdl/ipv4p_core.sv -----
// ----------------------------------------------------------------------------
// ipv4p_core
// Parse state and one-character update; forms the result for a terminator.
// ----------------------------------------------------------------------------
module ipv4p_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [ipv4p_pkg::CHAR_W-1:0]  ch,
	output ipv4p_pkg::parse_res_t         res
);
	import ipv4p_pkg::*;

	logic [VALUE_W-1:0] value_q, value_d;
	logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
	logic               lead0_q, lead0_d;
	logic [ADDR_W-1:0]  acc_q, acc_d;
	logic [OCNT_W-1:0]  ocnt_q, ocnt_d;
	logic               rej_q, rej_d;

	logic               is_digit;
	logic [VALUE_W-1:0] digit;
	logic [VALUE_W-1:0] value_x10;
	logic               octet_ok;

	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit     = VALUE_W'(ch - CH_ZERO);
	assign value_x10 = {value_q[VALUE_W-4:0], 3'b000} + {value_q[VALUE_W-2:0], 1'b0};
	assign octet_ok  = (dcnt_q != '0) && (value_q <= OCTET_MAX);

	always_comb begin
		res.ok   = !rej_q && octet_ok && (ocnt_q == LAST_DOTS);
		res.addr = res.ok ? {acc_q[ADDR_W-OCTET_W-1:0], value_q[OCTET_W-1:0]} : '0;
	end

	always_comb begin
		value_d = value_q;
		dcnt_d  = dcnt_q;
		lead0_d = lead0_q;
		acc_d   = acc_q;
		ocnt_d  = ocnt_q;
		rej_d   = rej_q;
		priority if (ch == CH_NUL) begin
			value_d = '0;
			dcnt_d  = '0;
			lead0_d = 1'b0;
			acc_d   = '0;
			ocnt_d  = '0;
			rej_d   = 1'b0;
		end else if (rej_q) begin
			// drain until terminator
		end else if (is_digit) begin
			if (dcnt_q == '0) begin
				lead0_d = (digit == '0);
				value_d = digit;
				dcnt_d  = DCNT_W'(1);
			end else if (dcnt_q >= MAX_DIGITS || lead0_q) begin
				rej_d = 1'b1;
			end else begin
				value_d = value_x10 + digit;
				dcnt_d  = dcnt_q + DCNT_W'(1);
			end
		end else if (ch == CH_DOT) begin
			if (!octet_ok || ocnt_q >= LAST_DOTS) begin
				rej_d = 1'b1;
			end else begin
				acc_d   = {acc_q[ADDR_W-OCTET_W-1:0], value_q[OCTET_W-1:0]};
				ocnt_d  = ocnt_q + OCNT_W'(1);
				value_d = '0;
				dcnt_d  = '0;
				lead0_d = 1'b0;
			end
		end else begin
			rej_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			dcnt_q  <= '0;
			lead0_q <= 1'b0;
			acc_q   <= '0;
			ocnt_q  <= '0;
			rej_q   <= 1'b0;
		end else if (step) begin
			value_q <= value_d;
			dcnt_q  <= dcnt_d;
			lead0_q <= lead0_d;
			acc_q   <= acc_d;
			ocnt_q  <= ocnt_d;
			rej_q   <= rej_d;
		end
	end

endmodule

// ----- tb/strict_ipv4_dotted_parser_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_ipv4_dotted_parser_test
// Streams NUL-terminated strings into the parser and checks every result
// against a cycle-free model of the dotted-quad rules kept in the bench.
// Directed strings hit each rejection path. Random strings follow, mostly
// well-formed quads, some broken, some noise, with idle and stall phases.
// ----------------------------------------------------------------------------
module strict_ipv4_dotted_parser_test;
	import ipv4p_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_CHARS    = 500;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		int unsigned       idle_pct;
		int unsigned       stall_pct;
		bit                hold;    // receiver holds off once this request goes out
		bit                drain;   // wait for all addresses before offering
	} char_req_t;

	typedef struct {
		logic [VALUE_W-1:0] val;
		logic [DCNT_W-1:0]  digits;
		bit                 lead_zero;
		logic [ADDR_W-1:0]  acc;
		logic [2:0]         dots;
		bit                 bad;
	} quad_state_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [CHAR_W-1:0]   s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [ADDR_W-1:0]   m_axis_tdata;
	logic                m_axis_tuser;

	char_req_t   pending[$];
	parse_res_t  addr_expect_q[$];
	quad_state_t quad_st = '{default: 0};
	int unsigned addrs_owed = 0;
	int unsigned addrs_seen = 0;
	int unsigned errors = 0;
	int unsigned rx_stall_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned quiet_cycles = 0;

	// fill-side plan, copied into each queued request
	int unsigned plan_idle = 0;
	int unsigned plan_stall = 0;
	bit          mark_hold = 1'b0;
	bit          mark_drain = 1'b0;

	strict_ipv4_dotted_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Folds one character into the quad state; returns 1 on a terminator.
	function automatic bit fold_char(input logic [CHAR_W-1:0] c, output parse_res_t res);
		res = '0;
		if (c == CH_NUL) begin
			res.ok = !quad_st.bad && quad_st.digits != 0 &&
				quad_st.dots == 3'(LAST_DOTS) && quad_st.val <= OCTET_MAX;
			res.addr = res.ok ? {quad_st.acc[ADDR_W-OCTET_W-1:0], quad_st.val[OCTET_W-1:0]} : '0;
			quad_st = '{default: 0};
			return 1'b1;
		end
		if (quad_st.bad)
			return 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (quad_st.digits == 0) begin
				quad_st.lead_zero = (c == CH_ZERO);
				quad_st.val = VALUE_W'(c - CH_ZERO);
				quad_st.digits = 1;
			end else if (quad_st.digits >= MAX_DIGITS || quad_st.lead_zero) begin
				quad_st.bad = 1'b1;
			end else begin
				quad_st.val = VALUE_W'(quad_st.val * 10 + (c - CH_ZERO));
				quad_st.digits = quad_st.digits + 1'b1;
			end
		end else if (c == CH_DOT) begin
			if (quad_st.digits == 0 || quad_st.dots >= 3'(LAST_DOTS) ||
					quad_st.val > OCTET_MAX) begin
				quad_st.bad = 1'b1;
			end else begin
				quad_st.acc = {quad_st.acc[ADDR_W-OCTET_W-1:0], quad_st.val[OCTET_W-1:0]};
				quad_st.dots = quad_st.dots + 1'b1;
				quad_st.val = '0;
				quad_st.digits = '0;
				quad_st.lead_zero = 1'b0;
			end
		end else begin
			quad_st.bad = 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_char(input logic [CHAR_W-1:0] c);
		char_req_t r;
		r.ch = c;
		r.idle_pct = plan_idle;
		r.stall_pct = plan_stall;
		r.hold = mark_hold;
		r.drain = mark_drain;
		mark_hold = 1'b0;
		mark_drain = 1'b0;
		pending.push_back(r);
	endtask

	// Queues a string plus terminator; bad_idx >= 0 swaps in bad_ch there.
	task automatic push_string(input string txt, input int bad_idx, input logic [CHAR_W-1:0] bad_ch);
		for (int i = 0; i < txt.len(); i++)
			push_char(i == bad_idx ? bad_ch : txt[i]);
		push_char(CH_NUL);
	endtask

	function automatic int unsigned pick_octet();
		case ($urandom_range(7))
			0: return 0;
			1: return 255;
			2: return $urandom_range(1, 9);
			3: return $urandom_range(10, 99);
			default: return $urandom_range(255);
		endcase
	endfunction

	task automatic push_random_string();
		string       part[4];
		string       txt;
		int unsigned kind;
		int unsigned flaw;
		int unsigned pos;
		int          bad_idx;
		int unsigned len;
		kind = $urandom_range(99);
		bad_idx = -1;
		if (kind < 70) begin
			for (int i = 0; i < 4; i++)
				part[i] = $sformatf("%0d", pick_octet());
			flaw = (kind >= 50) ? $urandom_range(1, 7) : 0;
			pos = $urandom_range(3);
			case (flaw)
				1: part[pos] = $sformatf("%0d", $urandom_range(256, 999));
				2: part[pos] = $sformatf("0%0d", $urandom_range(99));
				3: part[pos] = $sformatf("%0d", $urandom_range(1000, 9999));
				6: part[pos] = "";
				default: ;
			endcase
			if (flaw == 4)
				txt = {part[0], ".", part[1], ".", part[2]};
			else
				txt = {part[0], ".", part[1], ".", part[2], ".", part[3]};
			if (flaw == 5)
				txt = {txt, "."};
			if (flaw == 7 && txt.len() != 0)
				bad_idx = $urandom_range(txt.len() - 1);
			push_string(txt, bad_idx, CHAR_W'($urandom_range(1, 255)));
		end else begin
			// noise: short runs of digits, dots and arbitrary bytes
			len = $urandom_range(8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(1))
					push_char($urandom_range(10) == 10 ? CH_DOT : CHAR_W'(CH_ZERO + $urandom_range(9)));
				else
					push_char(CHAR_W'($urandom_range(1, 255)));
			end
			push_char(CH_NUL);
		end
	endtask

	// Sender: predicts on each accepted request, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		char_req_t   nxt;
		parse_res_t  res;
		bit          nul_in;
		int unsigned owed;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			hold_req <= 1'b0;
		end else begin
			nul_in = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				if (fold_char(s_axis_tdata, res)) begin
					addr_expect_q.push_back(res);
					nul_in = 1'b1;
				end
			end
			owed = addrs_owed + nul_in - addrs_seen;
			if (nul_in)
				addrs_owed <= addrs_owed + 1;
			if (s_axis_tvalid && !s_axis_tready) begin
				hold_req <= 1'b0;
			end else if (pending.size() != 0 && (!pending[0].drain || owed == 0) &&
					$urandom_range(99) >= pending[0].idle_pct) begin
				nxt = pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nxt.ch;
				hold_req <= nxt.hold;
				rx_stall_pct <= nxt.stall_pct;
			end else begin
				s_axis_tvalid <= 1'b0;
				hold_req <= 1'b0;
			end
		end
	end

	// Receiver: checks each address request, stalls at random or on a hold.
	always @(posedge clk or negedge arst_n) begin
		parse_res_t  want;
		int unsigned next_hold;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (addr_expect_q.size() == 0) begin
					$error("unexpected result: valid_res=%0b address=%08h", m_axis_tuser,
						m_axis_tdata);
					errors++;
				end else begin
					want = addr_expect_q.pop_front();
					if (m_axis_tuser !== want.ok) begin
						$error("valid_res: expected %0b, got %0b", want.ok, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata !== want.addr) begin
						$error("address: expected %08h, got %08h", want.addr, m_axis_tdata);
						errors++;
					end
				end
				addrs_seen <= addrs_seen + 1;
			end
			next_hold = hold_req ? HOLD_CYCLES : (hold_cnt != 0 ? hold_cnt - 1 : 0);
			hold_cnt <= next_hold;
			m_axis_tready <= next_hold == 0 && $urandom_range(99) >= rx_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("strict_ipv4_dotted_parser verification failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned phase_end;

		// directed: extremes and each rejection path
		push_string("", -1, CH_NUL);
		push_string("255.0.9.10", -1, CH_NUL);
		push_string("1..2", -1, CH_NUL);            // empty octet
		push_string("1000", -1, CH_NUL);            // fourth digit
		push_string("01", -1, CH_NUL);              // digit after leading zero
		push_string("256.", -1, CH_NUL);            // too big, closed by dot
		push_string("1.2.3.256", -1, CH_NUL);       // too big, closed by NUL
		push_string("1.2.3.4.", -1, CH_NUL);        // dot after the fourth octet
		push_string("1.2.3", -1, CH_NUL);           // short address
		push_string("/:1", 0, 8'hFF);               // non-digit, rest ignored
		push_string("9", 0, 8'h80);

		// pressure: hold the receiver while short strings pile up
		mark_hold = 1'b1;
		for (int i = 0; i < 40; i++)
			push_string(i % 2 ? "7" : "0.0.0.0", -1, CH_NUL);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin plan_idle = 0;  plan_stall = 0;  end
				1: begin plan_idle = 54; plan_stall = 0;  mark_drain = 1'b1; end
				2: begin plan_idle = 0;  plan_stall = 54; end
				default: begin plan_idle = 11; plan_stall = 11; end
			endcase
			phase_end = pending.size() + PHASE_CHARS;
			while (pending.size() < phase_end)
				push_random_string();
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending.size() != 0 || s_axis_tvalid || addrs_owed != addrs_seen);
		repeat (8) @(posedge clk);
		if (addr_expect_q.size() != 0) begin
			$error("%0d expected results never arrived", addr_expect_q.size());
			errors++;
		end
		if (errors == 0)
			$display("strict_ipv4_dotted_parser verification clean");
		else
			$display("strict_ipv4_dotted_parser verification failed");
		$finish;
	end

endmodule
